FILE: hdl/lgs_pkg.sv
// Shared types and constants for the Life generation stencil.
// No dependencies; the stencil top level takes what it needs by scoped names.
package lgs_pkg;

	// Configuration port geometry and register indexes.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;

	typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

	localparam cfg_index_t REG_GRID_WIDTH  = cfg_index_t'(0);
	localparam cfg_index_t REG_GRID_HEIGHT = cfg_index_t'(1);

	// Grid size after reset, and the smallest grid that has an interior cell.
	localparam int GRID_WIDTH_RST  = 80;
	localparam int GRID_HEIGHT_RST = 24;
	localparam int GRID_MIN        = 3;

	// Rule B3/S23: born with exactly three neighbors, survives with two or three.
	localparam logic [3:0] BIRTH_COUNT   = 4'd3;
	localparam logic [3:0] SURVIVE_COUNT = 4'd2;

	// Coordinates as reported on the result channel.
	localparam int COORD_W = 10;
	typedef logic [COORD_W-1:0] coord_t;

	// One result item as held in the output queue.
	typedef struct packed {
		logic   alive;
		coord_t row;
		coord_t col;
		logic   last;
	} result_t;

endpackage

FILE: hdl/life_generation_stencil.sv
// Life generation stencil, rule B3/S23, top level.
// Depends on lgs_pkg for types and constants and on lgs_ram for the row store.

// The block takes one cell per cycle as a row-major stream while cell_stall is low and,
// once two rows and two columns have arrived, returns one result per input cell: the next
// state of the cell one row up and one column left, with its coordinates and a flag on the
// last interior cell of the frame. The row store, a two-bit-wide RAM holding the two
// previous rows, is read for one column in the cycle a cell is accepted and written back
// for that column in the next cycle; each column is touched once per row, so the two
// accesses never meet. The row store needs no clearing after reset: every entry is
// written during the first two rows before any result depends on it. Border rows and
// columns count as dead. Writing grid_width or grid_height restarts the frame at row 0,
// column 0; write them only while the block is idle.
module life_generation_stencil #(
	parameter int MAX_COLUMNS = 1024,
	parameter int MAX_ROWS    = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,

	// Cell input channel.
	input  logic                          cell_valid,
	output logic                          cell_stall,
	input  logic                          cell_alive,

	// Result output channel.
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          next_alive,
	output logic [lgs_pkg::COORD_W-1:0]   cell_row,
	output logic [lgs_pkg::COORD_W-1:0]   cell_col,
	output logic                          frame_last,

	// Configuration write channel.
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lgs_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lgs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int WCMP_W = $clog2(MAX_COLUMNS + 1);
	localparam int HCMP_W = $clog2(MAX_ROWS + 1);
	localparam int CMP_W0 = (WCMP_W > HCMP_W) ? WCMP_W : HCMP_W;
	localparam int CMP_W  = (CMP_W0 > lgs_pkg::CFG_DATA_W) ? CMP_W0 : lgs_pkg::CFG_DATA_W;

	localparam int W_RST = (lgs_pkg::GRID_WIDTH_RST > MAX_COLUMNS) ?
		MAX_COLUMNS : lgs_pkg::GRID_WIDTH_RST;
	localparam int H_RST = (lgs_pkg::GRID_HEIGHT_RST > MAX_ROWS) ?
		MAX_ROWS : lgs_pkg::GRID_HEIGHT_RST;

	// Last column and last row of the grid, kept already clamped.
	logic [COL_W-1:0] w_last_q;
	logic [ROW_W-1:0] h_last_q;

	// Position of the next cell to arrive.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	// Three columns of three cells; newest column in the low bits.
	logic [8:0] window_q;

	// Stage 1: the cell whose row-store read is in flight.
	logic             valid_s1;
	logic             cur_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;

	// Two-entry output queue.
	lgs_pkg::result_t fifo_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       occ_q;

	logic             cell_accept;
	logic             result_pop;
	logic             cfg_write;
	logic             cfg_geometry;
	logic [2:0]       pending;
	logic             cur_in;
	logic [1:0]       ram_rdata;
	logic [8:0]       window_next;
	logic [3:0]       live_sum;
	logic [3:0]       neighbors;
	logic             centre;
	logic             emit_s1;
	logic             push;
	logic [ROW_W-1:0] row_m1;
	logic [COL_W-1:0] col_m1;
	logic [CMP_W-1:0] cfg_ext;
	logic [COL_W-1:0] w_last_new;
	logic [ROW_W-1:0] h_last_new;
	lgs_pkg::result_t result_s1;
	lgs_pkg::result_t result_head;

	// Handshakes. Each accepted cell needs a queue slot; count the one in stage 1 too.
	assign result_pop   = result_valid && !result_stall;
	assign pending      = {1'b0, occ_q} + {2'b00, valid_s1} - {2'b00, result_pop};
	assign cell_stall   = pending > 3'd1;
	assign cell_accept  = cell_valid && !cell_stall;
	assign cfg_ready    = 1'b1;
	assign cfg_write    = cfg_valid && cfg_ready;
	assign cfg_geometry = cfg_write &&
		(cfg_index == lgs_pkg::REG_GRID_WIDTH || cfg_index == lgs_pkg::REG_GRID_HEIGHT);

	// Clamp the written size into range and keep its last index.
	always_comb begin
		cfg_ext = CMP_W'(cfg_data);
		if (cfg_ext < CMP_W'(lgs_pkg::GRID_MIN)) begin
			w_last_new = COL_W'(lgs_pkg::GRID_MIN - 1);
			h_last_new = ROW_W'(lgs_pkg::GRID_MIN - 1);
		end else begin
			if (cfg_ext > CMP_W'(MAX_COLUMNS)) begin
				w_last_new = COL_W'(MAX_COLUMNS - 1);
			end else begin
				w_last_new = COL_W'(cfg_ext - CMP_W'(1));
			end
			if (cfg_ext > CMP_W'(MAX_ROWS)) begin
				h_last_new = ROW_W'(MAX_ROWS - 1);
			end else begin
				h_last_new = ROW_W'(cfg_ext - CMP_W'(1));
			end
		end
	end

	// Border cells are dead whatever the input says.
	assign cur_in = cell_alive && (row_q != '0) && (row_q != h_last_q) &&
		(col_q != '0) && (col_q != w_last_q);

	// Row store: bit 1 holds the row two above, bit 0 the row one above.
	lgs_ram #(
		.WIDTH (2),
		.DEPTH (MAX_COLUMNS)
	) u_row_store (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata ({ram_rdata[0], cur_s1}),
		.re    (cell_accept),
		.raddr (col_q),
		.rdata (ram_rdata)
	);

	// Shift the new column into the window and apply the rule.
	always_comb begin
		window_next = {window_q[5:0], ram_rdata[1], ram_rdata[0], cur_s1};
		live_sum    = '0;
		for (int i = 0; i < 9; i++) begin
			live_sum = live_sum + {3'b000, window_next[i]};
		end
		centre    = window_next[4];
		neighbors = live_sum - {3'b000, centre};
	end

	assign row_m1  = row_s1 - ROW_W'(1);
	assign col_m1  = col_s1 - COL_W'(1);
	assign emit_s1 = (row_s1 >= ROW_W'(2)) && (col_s1 >= COL_W'(2));
	assign push    = valid_s1 && emit_s1;

	always_comb begin
		result_s1.alive = (neighbors == lgs_pkg::BIRTH_COUNT) ||
			(centre && neighbors == lgs_pkg::SURVIVE_COUNT);
		result_s1.row   = lgs_pkg::coord_t'(row_m1);
		result_s1.col   = lgs_pkg::coord_t'(col_m1);
		result_s1.last  = (row_s1 == h_last_q) && (col_s1 == w_last_q);
	end

	// Control state: geometry, positions, window, stage valid, queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= COL_W'(W_RST - 1);
			h_last_q <= ROW_W'(H_RST - 1);
			col_q    <= '0;
			row_q    <= '0;
			window_q <= '0;
			valid_s1 <= 1'b0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			occ_q    <= '0;
		end else begin
			valid_s1 <= cell_accept;
			if (cfg_geometry) begin
				if (cfg_index == lgs_pkg::REG_GRID_WIDTH) begin
					w_last_q <= w_last_new;
				end else begin
					h_last_q <= h_last_new;
				end
				col_q    <= '0;
				row_q    <= '0;
				window_q <= '0;
			end else begin
				if (cell_accept) begin
					if (col_q == w_last_q) begin
						col_q <= '0;
						row_q <= (row_q == h_last_q) ? '0 : row_q + ROW_W'(1);
					end else begin
						col_q <= col_q + COL_W'(1);
					end
				end
				if (valid_s1) begin
					window_q <= window_next;
				end
			end
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (result_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			occ_q <= occ_q + {1'b0, push} - {1'b0, result_pop};
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (cell_accept) begin
			cur_s1 <= cur_in;
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
		if (push) begin
			fifo_q[wr_ptr_q] <= result_s1;
		end
	end

	// Result channel driven from the queue head.
	assign result_head  = fifo_q[rd_ptr_q];
	assign result_valid = occ_q != '0;
	assign next_alive   = result_head.alive;
	assign cell_row     = result_head.row;
	assign cell_col     = result_head.col;
	assign frame_last   = result_head.last;

	// A stage-1 cell always comes from a transfer in the previous cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> $past(cell_accept))
		else $error("stage 1 valid without a preceding input transfer");

	// The input stall keeps the output queue within its two entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= 2'd2)
		else $error("output queue overflow");

	// A transfer at the last column wraps the column to zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cell_accept && !cfg_geometry && col_q == w_last_q) |=> col_q == '0)
		else $error("column position failed to wrap at end of row");

endmodule

FILE: hdl/lgs_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// No dependencies.
module lgs_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
